[src/ssdp_pkg.sv]
// Shared types and constants for the size-spec decimal parser.
// No dependencies; imported by every module of the block.
package ssdp_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SYNTAX = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_POSITIVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_POW2     = 2'd1;

    // Largest suffix shift (g = 2^30)
    localparam int MAX_SHIFT = 30;
    localparam int SHIFT_W   = $clog2(MAX_SHIFT + 1);

    localparam int OUT_VALUE_W = 64;

    typedef struct packed {
        logic [7:0] character;
        logic       final_char;
    } t_in_word;

    typedef struct packed {
        logic [OUT_VALUE_W-1:0] parsed_value;
        logic [1:0]             status;
    } t_out_word;

    typedef struct packed {
        logic       req_positive;
        logic       req_pow2;
    } t_cfg;

    typedef struct packed {
        logic       digit_seen;
        logic       nondigit_seen;
        logic [1:0] err;
    } t_flags;

endpackage

[src/ssdp_step.sv]
// Per-character state transition: digit accumulate (x10 + d) or suffix scaling.
// Depends on ssdp_pkg.
module ssdp_step #(
    parameter int VALUE_WIDTH = 64
) (
    input  ssdp_pkg::t_in_word       i_word,
    input  logic [VALUE_WIDTH-1:0]   i_acc,
    input  ssdp_pkg::t_flags         i_flags,
    output logic [VALUE_WIDTH-1:0]   o_acc,
    output ssdp_pkg::t_flags         o_flags
);
    import ssdp_pkg::*;

    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_UP_A  = "A";
    localparam logic [7:0] CH_UP_Z  = "Z";
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef struct packed {
        logic               valid;
        logic [SHIFT_W-1:0] shift;
    } t_suffix;

    function automatic t_suffix suffix_decode(input logic [7:0] ch);
        logic [7:0] lc;
        t_suffix    s;
        lc = (ch >= CH_UP_A && ch <= CH_UP_Z) ? (ch | CASE_BIT) : ch;
        s.valid = 1'b1;
        unique case (lc)
            "c":     s.shift = SHIFT_W'(0);
            "w":     s.shift = SHIFT_W'(1);
            "b":     s.shift = SHIFT_W'(9);
            "k":     s.shift = SHIFT_W'(10);
            "m":     s.shift = SHIFT_W'(20);
            "g":     s.shift = SHIFT_W'(30);
            default: begin
                s.valid = 1'b0;
                s.shift = '0;
            end
        endcase
        return s;
    endfunction

    logic                             is_digit;
    logic [3:0]                       digit;
    logic [VALUE_WIDTH+3:0]           acc_x10;
    logic                             mul_ovf;
    t_suffix                          sfx;
    logic [VALUE_WIDTH+MAX_SHIFT-1:0] acc_shl;
    logic                             shl_ovf;

    assign is_digit = (i_word.character >= CH_ZERO) && (i_word.character <= CH_NINE);
    // ASCII digits sit at 0x30..0x39, so the low nibble is the digit value
    assign digit    = i_word.character[3:0];

    // acc*10 + d as (acc<<3) + (acc<<1) + d; any carry above the value width is overflow
    assign acc_x10 = ({4'b0, i_acc} << 3) + ({4'b0, i_acc} << 1)
                   + (VALUE_WIDTH+4)'(digit);
    assign mul_ovf = |acc_x10[VALUE_WIDTH+3:VALUE_WIDTH];

    assign sfx     = suffix_decode(i_word.character);
    assign acc_shl = {{MAX_SHIFT{1'b0}}, i_acc} << sfx.shift;
    assign shl_ovf = |acc_shl[VALUE_WIDTH+MAX_SHIFT-1:VALUE_WIDTH];

    always_comb begin
        o_acc   = i_acc;
        o_flags = i_flags;
        priority if (i_flags.nondigit_seen) begin
            // anything after the first nondigit
            if (i_flags.err == ST_OK) o_flags.err = ST_SYNTAX;
        end else if (is_digit) begin
            if (i_flags.err == ST_OK) begin
                if (mul_ovf) o_flags.err = ST_RANGE;
                else         o_acc = acc_x10[VALUE_WIDTH-1:0];
            end
            o_flags.digit_seen = 1'b1;
        end else begin
            o_flags.nondigit_seen = 1'b1;
            if (i_flags.err == ST_OK) begin
                priority if (!i_flags.digit_seen || !i_word.final_char) begin
                    o_flags.err = ST_SYNTAX;
                end else if (!sfx.valid) begin
                    o_flags.err = ST_SYNTAX;
                end else if (shl_ovf) begin
                    o_flags.err = ST_RANGE;
                end else begin
                    o_acc = acc_shl[VALUE_WIDTH-1:0];
                end
            end
        end
    end

endmodule

[src/ssdp_final.sv]
// Result formation on the last character: missing-digit, positive and power-of-two checks.
// Depends on ssdp_pkg.
module ssdp_final #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic [VALUE_WIDTH-1:0]  i_acc,
    input  ssdp_pkg::t_flags        i_flags,
    input  ssdp_pkg::t_cfg          i_cfg,
    output ssdp_pkg::t_out_word     o_word
);
    import ssdp_pkg::*;

    logic                   is_zero;
    logic                   is_pow2;
    logic [VALUE_WIDTH-1:0] acc_dec;
    logic [1:0]             st;

    assign is_zero = (i_acc == '0);
    assign acc_dec = i_acc - VALUE_WIDTH'(1);
    assign is_pow2 = !is_zero && ((i_acc & acc_dec) == '0);

    always_comb begin
        st = i_flags.err;
        if (st == ST_OK && !i_flags.digit_seen)          st = ST_SYNTAX;
        if (st == ST_OK && i_cfg.req_positive && is_zero) st = ST_RANGE;
        if (st == ST_OK && i_cfg.req_pow2 && !is_pow2)    st = ST_RANGE;
        o_word.status       = st;
        o_word.parsed_value = (st == ST_OK) ? OUT_VALUE_W'(i_acc) : '0;
    end

endmodule

[src/size_spec_decimal_parser_unit.sv]
// Top level of the size-spec decimal parser: input register, parse state, result register.
// Depends on ssdp_pkg, ssdp_step and ssdp_final.
//
//  channel  | direction | handshake                    | word
//  ---------+-----------+------------------------------+-------------------------------
//  in       | input     | i_in_valid / o_in_ready      | t_in_word  (character, final_char)
//  out      | output    | o_out_valid / i_out_ready    | t_out_word (parsed_value, status)
//  cfg      | input     | i_cfg_wr_en (no wait)        | i_cfg_index, i_cfg_data
//
// One character word per cycle, sustained unless a final character waits on a
// stalled output. An accepted word is decoded while it sits in the input register:
// the x10/add/compare or suffix shift runs there and the parse state updates as the
// word advances; a final character's result then goes to the result register.
// Reset is synchronous (i_rst_n low): parse state, flags, config and valids clear.
// An output stall holds only a final character in the input register; other
// characters keep flowing into the parse state while a result waits.
module size_spec_decimal_parser_unit #(
    parameter int VALUE_WIDTH = 64   // accumulator width, 32..64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  ssdp_pkg::t_in_word                   i_in_word,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output ssdp_pkg::t_out_word                  o_out_word,
    input  logic                                 i_cfg_wr_en,
    input  logic [ssdp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ssdp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import ssdp_pkg::*;

    // input stage
    logic                   r_in_valid;
    t_in_word               r_in;

    // parse state
    logic [VALUE_WIDTH-1:0] r_acc;
    t_flags                 r_flags;
    t_cfg                   r_cfg;

    // result stage
    logic                   r_out_valid;
    t_out_word              r_out;

    logic [VALUE_WIDTH-1:0] n_acc;
    t_flags                 n_flags;
    t_out_word              n_out;
    logic                   out_free;
    logic                   advance;

    ssdp_step #(.VALUE_WIDTH(VALUE_WIDTH)) u_step (
        .i_word  (r_in),
        .i_acc   (r_acc),
        .i_flags (r_flags),
        .o_acc   (n_acc),
        .o_flags (n_flags)
    );

    // result is formed from the state after this character's update
    ssdp_final #(.VALUE_WIDTH(VALUE_WIDTH)) u_final (
        .i_acc   (n_acc),
        .i_flags (n_flags),
        .i_cfg   (r_cfg),
        .o_word  (n_out)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    // a non-final character never needs the result slot
    assign advance    = r_in_valid && (!r_in.final_char || out_free);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
            r_flags     <= '0;
            r_cfg       <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
                r_in       <= i_in_word;
            end

            if (advance) begin
                if (r_in.final_char) begin
                    // string done: clear for the next one
                    r_acc   <= '0;
                    r_flags <= '0;
                end else begin
                    r_acc   <= n_acc;
                    r_flags <= n_flags;
                end
            end

            if (out_free) begin
                r_out_valid <= advance && r_in.final_char;
                r_out       <= n_out;
            end

            // config must only change while idle; the user is bound, the block has no interlock
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_REQ_POSITIVE) r_cfg.req_positive <= i_cfg_data[0];
                if (i_cfg_index == CFG_REQ_POW2)     r_cfg.req_pow2     <= i_cfg_data[0];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

[src/ssdp_checker.sv]
// Port-level checks for the size-spec decimal parser, bound to the top level.
// Depends on ssdp_pkg and size_spec_decimal_parser_unit.
module ssdp_port_props #(
    parameter int VALUE_WIDTH = 64
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input ssdp_pkg::t_out_word  o_out_word
);
    import ssdp_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result changed or dropped");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.status == ST_OK || o_out_word.status == ST_SYNTAX ||
                         o_out_word.status == ST_RANGE))
        else $error("undefined status code");

    a_err_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status != ST_OK |-> o_out_word.parsed_value == '0)
        else $error("error result with nonzero value");

    a_value_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.parsed_value >> VALUE_WIDTH) == '0)
        else $error("value wider than accumulator");

endmodule

bind size_spec_decimal_parser_unit ssdp_port_props #(.VALUE_WIDTH(VALUE_WIDTH)) u_ssdp_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
